[hw/rtl/ffa_pkg.sv]
// Shared constants, types and helpers of the first-fit block allocator.
package ffa_pkg;

  localparam int NUM_BLOCKS   = 256;
  localparam int BLOCK_BYTES  = 64;
  localparam int HEADER_BYTES = 16;

  localparam int SIZE_W  = 16;                        // request_bytes field
  localparam int IDXF_W  = 8;                         // block_index / start_block field
  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int RUN_W   = IDX_W + 1;
  localparam int MAX_NEED = ((2 ** SIZE_W) - 1 + HEADER_BYTES) / BLOCK_BYTES + 1;
  localparam int NEED_W  = $clog2(MAX_NEED + 1);
  localparam int CMP_W   = (NEED_W > RUN_W) ? NEED_W : RUN_W;
  localparam int CNT_W   = CMP_W + 1;

  localparam int S_DATA_W = 24;                       // request_bytes, block_index
  localparam int M_DATA_W = 8;                        // start_block

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;
  localparam logic ST_DONE      = 1'b0;
  localparam logic ST_OOM       = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic walk_set;
    logic walk_clr;
    logic count;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic in_oob;
    logic hit;
    logic scan_last;
    logic walk_last;
    logic out_free;
  } stat_t;

  // Blocks covered by an allocation of the given byte size.
  function automatic logic [NEED_W-1:0] blocks_for(input logic [SIZE_W-1:0] bytes);
    logic [SIZE_W:0] sum;
    sum = {1'b0, bytes} + (SIZE_W + 1)'(HEADER_BYTES);
    return NEED_W'(sum / (SIZE_W + 1)'(BLOCK_BYTES)) + NEED_W'(1);
  endfunction

endpackage

[hw/rtl/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/ffa_ctrl.sv]
// Sequencer of the allocator: steps the datapath through scan, mark and free.
module ffa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  ffa_pkg::stat_t stat,
  output ffa_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    MARK,
    READ,
    COUNT,
    FREE,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (stat.in_alloc) begin
            state_next = SCAN;
          end else if (stat.in_oob) begin
            state_next = DONE;
          end else begin
            state_next = READ;
          end
        end
      end
      SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          state_next = MARK;
        end else if (stat.scan_last) begin
          state_next = DONE;
        end
      end
      MARK: begin
        cmd.walk_set = 1'b1;
        if (stat.walk_last) begin
          state_next = DONE;
        end
      end
      // wait out the registered read of the stored size
      READ: begin
        state_next = COUNT;
      end
      COUNT: begin
        cmd.count  = 1'b1;
        state_next = FREE;
      end
      FREE: begin
        cmd.walk_clr = 1'b1;
        if (stat.walk_last) begin
          state_next = DONE;
        end
      end
      DONE: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign s_tready = (state == IDLE);

endmodule

[hw/rtl/ffa_dp.sv]
// Datapath: block map, stored sizes, scan and walk counters, result register.
module ffa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tuser,
  input  logic [ffa_pkg::S_DATA_W-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tuser,
  output logic [ffa_pkg::M_DATA_W-1:0]  m_tdata,
  input  ffa_pkg::cmd_t                 cmd,
  output ffa_pkg::stat_t                stat
);

  logic [ffa_pkg::NUM_BLOCKS-1:0] size_valid;

  logic                         alloc;
  logic                         found;
  logic [ffa_pkg::SIZE_W-1:0]   bytes;
  logic [ffa_pkg::NEED_W-1:0]   need;
  logic [ffa_pkg::IDX_W-1:0]    index;
  logic [ffa_pkg::IDX_W-1:0]    idx;
  logic [ffa_pkg::RUN_W-1:0]    run;
  logic [ffa_pkg::IDX_W-1:0]    first;
  logic [ffa_pkg::IDX_W-1:0]    k;
  logic [ffa_pkg::IDX_W-1:0]    end_last;
  logic                         rd_valid;

  logic [ffa_pkg::RUN_W-1:0]    run_inc;
  logic [ffa_pkg::IDX_W-1:0]    hit_first;
  logic                         hit;
  logic [ffa_pkg::IDX_W-1:0]    raddr;
  logic [ffa_pkg::SIZE_W:0]     rd_word;
  logic [ffa_pkg::SIZE_W:0]     wr_word;
  logic [ffa_pkg::SIZE_W:0]     ent;
  logic                         blk_used;
  logic [ffa_pkg::SIZE_W-1:0]   eff_size;
  logic [ffa_pkg::CNT_W-1:0]    end_sum;
  logic [ffa_pkg::CNT_W-1:0]    end_clip;
  logic [ffa_pkg::IDXF_W-1:0]   in_index;

  assign in_index  = s_tdata[ffa_pkg::SIZE_W +: ffa_pkg::IDXF_W];
  assign run_inc   = run + ffa_pkg::RUN_W'(1);

  // an entry not written since reset or its last free reads as free with size zero
  assign ent       = rd_valid ? rd_word : '0;
  assign blk_used  = ent[ffa_pkg::SIZE_W];
  assign eff_size  = ent[ffa_pkg::SIZE_W-1:0];

  assign hit       = !blk_used &&
                     (ffa_pkg::CMP_W'(run_inc) >= ffa_pkg::CMP_W'(need));
  assign hit_first = idx - ffa_pkg::IDX_W'(run);

  // read one entry ahead of the scan; block 0 is read as the item is taken
  assign raddr = cmd.scan ? idx + ffa_pkg::IDX_W'(1) : (cmd.load ? '0 : index);

  // mark the run used; only its start block keeps the size
  assign wr_word = {1'b1, (k == first) ? bytes : {ffa_pkg::SIZE_W{1'b0}}};

  assign end_sum  = ffa_pkg::CNT_W'(index) + ffa_pkg::CNT_W'(ffa_pkg::blocks_for(eff_size));
  assign end_clip = (end_sum > ffa_pkg::CNT_W'(ffa_pkg::NUM_BLOCKS)) ?
                    ffa_pkg::CNT_W'(ffa_pkg::NUM_BLOCKS) : end_sum;

  always_comb begin
    stat           = '0;
    stat.in_alloc  = (s_tuser == ffa_pkg::MODE_ALLOC);
    stat.in_oob    = (32'(in_index) >= 32'(ffa_pkg::NUM_BLOCKS));
    stat.hit       = hit;
    stat.scan_last = (idx == ffa_pkg::IDX_W'(ffa_pkg::NUM_BLOCKS - 1));
    stat.walk_last = (k == end_last);
    stat.out_free  = !m_tvalid || m_tready;
  end

  ffa_ram #(
    .WIDTH (ffa_pkg::SIZE_W + 1),
    .DEPTH (ffa_pkg::NUM_BLOCKS)
  ) u_size_ram (
    .clk   (clk),
    .we    (cmd.walk_set),
    .waddr (k),
    .wdata (wr_word),
    .raddr (raddr),
    .rdata (rd_word)
  );

  // control state: entry valid bits, found flag, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      size_valid <= '0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        found <= 1'b0;
      end
      if (cmd.scan && hit) begin
        found <= 1'b1;
      end
      if (cmd.walk_set) begin
        size_valid[k] <= 1'b1;
      end
      if (cmd.walk_clr) begin
        size_valid[k] <= 1'b0;
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload and counters
  always_ff @(posedge clk) begin
    rd_valid <= size_valid[raddr];
    if (cmd.load) begin
      alloc <= (s_tuser == ffa_pkg::MODE_ALLOC);
      bytes <= s_tdata[ffa_pkg::SIZE_W-1:0];
      need  <= ffa_pkg::blocks_for(s_tdata[ffa_pkg::SIZE_W-1:0]);
      index <= ffa_pkg::IDX_W'(in_index);
      idx   <= '0;
      run   <= '0;
    end
    if (cmd.scan) begin
      idx <= idx + ffa_pkg::IDX_W'(1);
      run <= blk_used ? '0 : run_inc;
      if (hit) begin
        first    <= hit_first;
        k        <= hit_first;
        end_last <= idx;
      end
    end
    if (cmd.count) begin
      k        <= index;
      end_last <= ffa_pkg::IDX_W'(end_clip - ffa_pkg::CNT_W'(1));
    end
    if (cmd.walk_set || cmd.walk_clr) begin
      k <= k + ffa_pkg::IDX_W'(1);
    end
    if (cmd.emit) begin
      m_tuser <= (alloc && !found) ? ffa_pkg::ST_OOM : ffa_pkg::ST_DONE;
      m_tdata <= (alloc && found) ? ffa_pkg::M_DATA_W'(first) : '0;
    end
  end

`ifndef ASSERT_OFF
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("result loaded over an item not yet taken");

  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.walk_set, cmd.walk_clr, cmd.count, cmd.emit}))
    else $error("datapath commands overlap");

  a_hit_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan && hit) |=> (k == first) && found)
    else $error("run start not captured on a fit");
`endif

endmodule

[hw/rtl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: sequencer plus datapath.
//
//  channel  dir  tdata                                  tuser
//  s_*      in   [15:0] request_bytes, [23:16] block_index  mode
//  m_*      out  [7:0] start_block                      status
//
// Allocate: a one-block-a-cycle scan of at most NUM_BLOCKS blocks of the block map,
// then the walk that marks the run.
// Release: a registered read of the stored size, then the freeing walk.
// Reset clears all valid bits at once: blocks read free, size 0; no clearing pass.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and its result waits until the previous one is taken.
module first_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic                          s_tuser,   // mode
  input  logic [ffa_pkg::S_DATA_W-1:0]  s_tdata,   // request_bytes, block_index
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tuser,   // status
  output logic [ffa_pkg::M_DATA_W-1:0]  m_tdata    // start_block
);

  ffa_pkg::cmd_t  cmd;
  ffa_pkg::stat_t stat;

  ffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule
